>>> src/qvs_pkg.sv
// Package for the quadrature velocity stepper: request/response payloads,
// per-motor control and status structs, command/outcome codes, register indexes.
// No dependencies.
package qvs_pkg;

   // Request kinds
   localparam logic CMD_SET  = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Outcome codes reported with every response
   localparam logic [2:0] OUT_QUEUED    = 3'd0;
   localparam logic [2:0] OUT_RANGE     = 3'd1;
   localparam logic [2:0] OUT_REDUNDANT = 3'd2;
   localparam logic [2:0] OUT_FAULTED   = 3'd3;
   localparam logic [2:0] OUT_BUSY      = 3'd4;
   localparam logic [2:0] OUT_TICK      = 3'd5;

   // Control register indexes
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_VELOCITY = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_VELOCITY_RES = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_AUTO_CLEAR   = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_EDGE_DELAY   = 2'd3;

   // Register reset values
   localparam logic [14:0] MAX_VELOCITY_RST = 15'd4000;
   localparam logic [14:0] VELOCITY_RES_RST = 15'd1;
   localparam logic        AUTO_CLEAR_RST   = 1'b1;
   localparam logic [15:0] EDGE_DELAY_RST   = 16'd1;

   // Divider operand widths: dividend is 2*|v| + res, divisor is 2*res
   localparam int DIVIDEND_W = 17;
   localparam int DIVISOR_W  = 16;

   typedef struct packed {
      logic               cmd;
      logic               motor_sel;
      logic signed [15:0] target_rpm;
      logic               motor_fault;
   } qvs_req_type;

   typedef struct packed {
      logic       top_in_a;
      logic       top_in_b;
      logic       bottom_in_a;
      logic       bottom_in_b;
      logic [2:0] outcome;
      logic       clear_request;
      logic       top_busy;
      logic       bottom_busy;
   } qvs_rsp_type;

   // Per-motor strobes from the sequencer
   typedef struct packed {
      logic tick;
      logic clear;
      logic load;
   } qvs_axis_ctl_type;

   // Values written into a motor when a command is queued
   typedef struct packed {
      logic [15:0]        pulses;
      logic               step_up;
      logic signed [15:0] commanded;
   } qvs_axis_load_type;

   // Per-motor status seen by the sequencer and the response
   typedef struct packed {
      logic signed [15:0] commanded;
      logic               busy;
      logic [1:0]         pins;
   } qvs_axis_stat_type;

endpackage

>>> src/qvs_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on qvs_pkg for operand widths.
module qvs_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [qvs_pkg::DIVIDEND_W-1:0]    dividend,
   input  logic [qvs_pkg::DIVISOR_W-1:0]     divisor,
   output logic                              done,
   output logic [qvs_pkg::DIVIDEND_W-1:0]    quotient
);

   localparam int NW    = qvs_pkg::DIVIDEND_W;
   localparam int DW    = qvs_pkg::DIVISOR_W;
   localparam int CNT_W = $clog2(NW + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [NW-1:0]    quo_ff, quo_in;
   logic [DW-1:0]    divisor_ff, divisor_in;
   logic [DW:0]      trial;

   // One shift-subtract step per cycle; start overrides any run, finished or not
   always_comb begin
      busy_in    = busy_ff;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      trial      = {rem_ff, quo_ff[NW-1]};
      if (start) begin
         busy_in    = 1'b1;
         count_in   = CNT_W'(NW);
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         if (count_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            count_in = count_ff - 1'b1;
            if (trial >= {1'b0, divisor_ff}) begin
               rem_in = DW'(trial - {1'b0, divisor_ff});
               quo_in = {quo_ff[NW-2:0], 1'b1};
            end else begin
               rem_in = trial[DW-1:0];
               quo_in = {quo_ff[NW-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign done     = busy_ff && (count_ff == '0);
   assign quotient = quo_ff;

endmodule

>>> src/qvs_axis.sv
// Quadrature edge generator for one motor: commanded velocity, pulse queue,
// edge phase, delay counter and pin levels. Depends on qvs_pkg.
module qvs_axis (
   input  logic                       clock,
   input  logic                       reset,
   input  qvs_pkg::qvs_axis_ctl_type  ctl,
   input  qvs_pkg::qvs_axis_load_type load_data,
   input  logic [15:0]                edge_delay,
   output qvs_pkg::qvs_axis_stat_type status
);

   logic signed [15:0] commanded_ff, commanded_in;
   logic [15:0]        pulses_ff, pulses_in;
   logic [1:0]         phase_ff, phase_in;
   logic               step_up_ff, step_up_in;
   logic [15:0]        delay_ff, delay_in;
   logic [1:0]         pins_ff, pins_in;
   logic [15:0]        delay_eff;
   logic [15:0]        delay_next;
   logic [1:0]         lead;
   logic [1:0]         other;

   always_comb begin
      commanded_in = commanded_ff;
      pulses_in    = pulses_ff;
      phase_in     = phase_ff;
      step_up_in   = step_up_ff;
      delay_in     = delay_ff;
      pins_in      = pins_ff;
      delay_eff    = (edge_delay == '0) ? 16'd1 : edge_delay;
      delay_next   = delay_ff + 16'd1;
      // Rising direction leads with A, falling with B
      lead         = step_up_ff ? 2'b01 : 2'b10;
      other        = ~lead;
      if (ctl.load) begin
         // Queue a new pulse train
         commanded_in = load_data.commanded;
         pulses_in    = load_data.pulses;
         step_up_in   = load_data.step_up;
         phase_in     = '0;
         delay_in     = '0;
      end else if (ctl.clear) begin
         // Fault drops the commanded velocity
         commanded_in = '0;
      end else if (ctl.tick && (pulses_ff != '0)) begin
         // Advance the delay; fire an edge when it expires
         if (delay_next < delay_eff) begin
            delay_in = delay_next;
         end else begin
            delay_in = '0;
            case (phase_ff)
               2'd0:    pins_in = pins_ff | lead;
               2'd1:    pins_in = pins_ff | other;
               2'd2:    pins_in = pins_ff & ~lead;
               default: pins_in = pins_ff & ~other;
            endcase
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd3) begin
               pulses_in = pulses_ff - 16'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         commanded_ff <= '0;
         pulses_ff    <= '0;
         phase_ff     <= '0;
         step_up_ff   <= 1'b0;
         delay_ff     <= '0;
         pins_ff      <= '0;
      end else begin
         commanded_ff <= commanded_in;
         pulses_ff    <= pulses_in;
         phase_ff     <= phase_in;
         step_up_ff   <= step_up_in;
         delay_ff     <= delay_in;
         pins_ff      <= pins_in;
      end
   end

   assign status.commanded = commanded_ff;
   assign status.busy      = (pulses_ff != '0);
   assign status.pins      = pins_ff;

endmodule

>>> src/quadrature_velocity_stepper.sv
// Quadrature velocity stepper top level: request checks, sequencer around the
// shared divider, per-motor edge generators, response register.
// Depends on qvs_pkg, qvs_div and qvs_axis.
// Tick and rejected set requests go through ST_REPORT into the response
// register; a queued set request first runs ST_DIV_A, ST_DIV_B and ST_LOAD.
// Throughput: one request at a time; the single shared divider runs twice
// per queued request. Reset is synchronous and active high: it clears all
// motor state, pins low, registers to their defaults, response slot empty.
module quadrature_velocity_stepper #(
   parameter int NUM_MOTORS = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  qvs_pkg::qvs_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output qvs_pkg::qvs_rsp_type                rsp_data,
   input  logic                                csr_we,
   input  logic [qvs_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [qvs_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int NW = qvs_pkg::DIVIDEND_W;
   localparam int DW = qvs_pkg::DIVISOR_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_A,
      ST_DIV_B,
      ST_LOAD,
      ST_REPORT
   } state_type;

   // Control registers
   logic [14:0] max_vel_ff;
   logic [14:0] res_ff;
   logic        auto_clear_ff;
   logic [15:0] edge_delay_ff;

   // Sequencer state and held request
   state_type          state_ff, state_in;
   logic               sel_ff, sel_in;
   logic signed [15:0] adj_ff, adj_in;
   logic [NW-1:0]      qa_ff, qa_in;
   logic [NW-1:0]      qb_ff, qb_in;
   logic               neg_b_ff, neg_b_in;
   logic [2:0]         outcome_ff, outcome_in;
   logic               clr_ff, clr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   qvs_pkg::qvs_rsp_type rsp_data_ff, rsp_data_in;

   // Motor array
   qvs_pkg::qvs_axis_ctl_type  axis_ctl  [NUM_MOTORS];
   qvs_pkg::qvs_axis_stat_type axis_stat [NUM_MOTORS];
   qvs_pkg::qvs_axis_load_type load_data;

   // Divider
   logic          div_start;
   logic [NW-1:0] div_dividend;
   logic [DW-1:0] div_divisor;
   logic          div_done;
   logic [NW-1:0] div_quotient;

   // Combinational helpers
   logic                       req_acc;
   logic                       mux_sel;
   logic [NUM_MOTORS-1:0]      hit;
   logic                       motor_ok;
   qvs_pkg::qvs_axis_stat_type cur;
   logic signed [15:0]         target;
   logic signed [15:0]         adj_req;
   logic [2:0]                 check;
   logic [14:0]                res_eff;
   logic [15:0]                cmd_mag;
   logic signed [NW:0]         qa_s;
   logic signed [NW:0]         qb_s;
   logic signed [NW:0]         diff_s;
   logic [NW:0]                diff_abs;

   assign req_acc   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Write control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_vel_ff    <= qvs_pkg::MAX_VELOCITY_RST;
         res_ff        <= qvs_pkg::VELOCITY_RES_RST;
         auto_clear_ff <= qvs_pkg::AUTO_CLEAR_RST;
         edge_delay_ff <= qvs_pkg::EDGE_DELAY_RST;
      end else if (csr_we) begin
         case (csr_addr)
            qvs_pkg::CSR_MAX_VELOCITY: max_vel_ff    <= csr_wdata[14:0];
            qvs_pkg::CSR_VELOCITY_RES: res_ff        <= csr_wdata[14:0];
            qvs_pkg::CSR_AUTO_CLEAR:   auto_clear_ff <= csr_wdata[0];
            qvs_pkg::CSR_EDGE_DELAY:   edge_delay_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Select the addressed motor and check a set request
   always_comb begin
      mux_sel = (state_ff == ST_IDLE) ? req_data.motor_sel : sel_ff;
      for (int i = 0; i < NUM_MOTORS; i++) begin
         hit[i] = (i == 32'(mux_sel));
      end
      motor_ok = |hit;
      cur      = '0;
      for (int i = 0; i < NUM_MOTORS; i++) begin
         if (hit[i]) begin
            cur = axis_stat[i];
         end
      end
      target  = req_data.target_rpm;
      adj_req = req_data.motor_sel ? -target : target;
      if (!motor_ok) begin
         check = qvs_pkg::OUT_RANGE;
      end else if (cur.busy) begin
         check = qvs_pkg::OUT_BUSY;
      end else if (target[15] || (target[14:0] > max_vel_ff)) begin
         check = qvs_pkg::OUT_RANGE;
      end else if (adj_req == cur.commanded) begin
         check = qvs_pkg::OUT_REDUNDANT;
      end else if (req_data.motor_fault) begin
         check = qvs_pkg::OUT_FAULTED;
      end else begin
         check = qvs_pkg::OUT_QUEUED;
      end
   end

   // Build the two rounded-division operands and the pulse count
   always_comb begin
      res_eff     = (res_ff == '0) ? 15'd1 : res_ff;
      div_divisor = {res_eff, 1'b0};
      // Commanded magnitude stays below 2^15: it only ever holds +/- a target
      cmd_mag     = cur.commanded[15] ? 16'(-cur.commanded) : cur.commanded;
      div_start   = 1'b0;
      div_dividend = {1'b0, target[14:0], 1'b0} + NW'(res_eff);
      if ((state_ff == ST_IDLE) && req_acc && (req_data.cmd == qvs_pkg::CMD_SET) &&
          (check == qvs_pkg::OUT_QUEUED)) begin
         div_start = 1'b1;
      end else if ((state_ff == ST_DIV_A) && div_done) begin
         div_start    = 1'b1;
         div_dividend = {1'b0, cmd_mag[14:0], 1'b0} + NW'(res_eff);
      end
      qa_s     = sel_ff ? -$signed({1'b0, qa_ff}) : $signed({1'b0, qa_ff});
      qb_s     = neg_b_ff ? -$signed({1'b0, qb_ff}) : $signed({1'b0, qb_ff});
      diff_s   = qa_s - qb_s;
      diff_abs = diff_s[NW] ? (NW + 1)'(-diff_s) : diff_s;
      load_data.pulses    = diff_abs[15:0];
      load_data.step_up   = (adj_ff > cur.commanded);
      load_data.commanded = adj_ff;
   end

   // Per-motor strobes
   always_comb begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
         axis_ctl[i].tick  = (state_ff == ST_IDLE) && req_acc &&
                             (req_data.cmd == qvs_pkg::CMD_TICK);
         axis_ctl[i].clear = (state_ff == ST_IDLE) && req_acc &&
                             (req_data.cmd == qvs_pkg::CMD_SET) &&
                             (check == qvs_pkg::OUT_FAULTED) && hit[i];
         axis_ctl[i].load  = (state_ff == ST_LOAD) && hit[i];
      end
   end

   // Sequencer next state and response
   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      adj_in       = adj_ff;
      qa_in        = qa_ff;
      qb_in        = qb_ff;
      neg_b_in     = neg_b_ff;
      outcome_in   = outcome_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               sel_in   = req_data.motor_sel;
               adj_in   = adj_req;
               clr_in   = 1'b0;
               state_in = ST_REPORT;
               if (req_data.cmd == qvs_pkg::CMD_TICK) begin
                  outcome_in = qvs_pkg::OUT_TICK;
               end else begin
                  outcome_in = check;
                  if (check == qvs_pkg::OUT_FAULTED) begin
                     clr_in = auto_clear_ff;
                  end else if (check == qvs_pkg::OUT_QUEUED) begin
                     state_in = ST_DIV_A;
                  end
               end
            end
         end
         ST_DIV_A: begin
            if (div_done) begin
               qa_in    = div_quotient;
               neg_b_in = cur.commanded[15];
               state_in = ST_DIV_B;
            end
         end
         ST_DIV_B: begin
            if (div_done) begin
               qb_in    = div_quotient;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            // Motor state is settled; capture the response
            rsp_valid_in              = 1'b1;
            rsp_data_in               = '0;
            rsp_data_in.outcome       = outcome_ff;
            rsp_data_in.clear_request = clr_ff;
            for (int i = 0; i < NUM_MOTORS; i++) begin
               if (i == 0) begin
                  rsp_data_in.top_in_a = axis_stat[i].pins[0];
                  rsp_data_in.top_in_b = axis_stat[i].pins[1];
                  rsp_data_in.top_busy = axis_stat[i].busy;
               end else if (i == 1) begin
                  rsp_data_in.bottom_in_a = axis_stat[i].pins[0];
                  rsp_data_in.bottom_in_b = axis_stat[i].pins[1];
                  rsp_data_in.bottom_busy = axis_stat[i].busy;
               end
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sel_ff      <= sel_in;
      adj_ff      <= adj_in;
      qa_ff       <= qa_in;
      qb_ff       <= qb_in;
      neg_b_ff    <= neg_b_in;
      outcome_ff  <= outcome_in;
      clr_ff      <= clr_in;
      rsp_data_ff <= rsp_data_in;
   end

   qvs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   for (genvar g = 0; g < NUM_MOTORS; g++) begin : g_axis
      qvs_axis u_axis (
         .clock      (clock),
         .reset      (reset),
         .ctl        (axis_ctl[g]),
         .load_data  (load_data),
         .edge_delay (edge_delay_ff),
         .status     (axis_stat[g])
      );
   end

   // A response is only built into an empty slot
   a_report_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPORT) |-> !rsp_valid_ff)
      else $error("response built while slot occupied");

   // The divider finishes only while the sequencer waits for it
   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> ((state_ff == ST_DIV_A) || (state_ff == ST_DIV_B)))
      else $error("divider result with no waiting step");

   // A pulse train is loaded only into an idle motor
   a_load_idle_motor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> (motor_ok && !cur.busy))
      else $error("pulse train loaded into busy or absent motor");

   // A queued request leaves the idle state for the divider
   a_queued_divides: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_IDLE) && req_acc && (req_data.cmd == qvs_pkg::CMD_SET) &&
       (check == qvs_pkg::OUT_QUEUED)) |=> (state_ff == ST_DIV_A))
      else $error("queued request did not start the divider");

endmodule
